[sv/tzl_pkg.sv]
// Package for the time-zone transition lookup block.
// Holds the command and status codes, the sequencer states and the result record.
// Has no dependencies; tzl_scan and tz_transition_lookup refer to it by scoped names.
package tzl_pkg;

	localparam int DEF_MAX_TRANSITIONS = 1024;
	localparam int DEF_MAX_TYPES       = 64;

	localparam int CMD_W      = 2;
	localparam int INDEX_W    = 10;
	localparam int TTIME_W    = 32;
	localparam int TTYPE_W    = 8;
	localparam int OFFSET_W   = 32;
	localparam int ABBREV_W   = 8;
	localparam int QTIME_W    = 64;
	localparam int STATUS_W   = 2;
	localparam int TRCFG_W    = 11;
	localparam int TYCFG_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 48;

	localparam int TR_ENTRY_W = TTIME_W + TTYPE_W;
	localparam int TY_ENTRY_W = OFFSET_W + 1 + ABBREV_W;

	localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_COUNT       = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_TRANS = 2'd0,
		CMD_WR_TYPE  = 2'd1,
		CMD_QUERY    = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_DATA  = 2'd1,
		STATUS_BAD_TYPE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TYPE_RD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                valid;
		status_t             status;
		logic [OFFSET_W-1:0] offset;
		logic                dst;
		logic [ABBREV_W-1:0] abbrev;
	} result_t;

endpackage

[sv/tzl_ram.sv]
// Single-port synchronous RAM with a registered read.
// Used for the transition table and the type table; depends on nothing else.
module tzl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[sv/tzl_scan.sv]
// Sequencer of the lookup: takes input transfers, writes the tables and walks the
// transition table for a query, then reads the selected type. Depends on tzl_pkg.
module tzl_scan #(
	parameter int MAX_TRANSITIONS = tzl_pkg::DEF_MAX_TRANSITIONS,
	parameter int MAX_TYPES       = tzl_pkg::DEF_MAX_TYPES,
	localparam int TR_AW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1,
	localparam int TY_AW  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1,
	localparam int TRC_W  = $clog2(MAX_TRANSITIONS + 1),
	localparam int TYC_W  = $clog2(MAX_TYPES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tzl_pkg::CMD_W-1:0]           cmd,
	input  logic [tzl_pkg::INDEX_W-1:0]         entry_index,
	input  logic [tzl_pkg::TTIME_W-1:0]         transition_time,
	input  logic [tzl_pkg::TTYPE_W-1:0]         transition_type,
	input  logic [tzl_pkg::OFFSET_W-1:0]        type_offset,
	input  logic                                type_dst,
	input  logic [tzl_pkg::ABBREV_W-1:0]        type_abbrev,
	input  logic signed [tzl_pkg::QTIME_W-1:0]  query_time,
	input  logic [TRC_W-1:0]                    ntr,
	input  logic [TYC_W-1:0]                    nty,
	output logic                                tr_we,
	output logic [TR_AW-1:0]                    tr_addr,
	output logic [tzl_pkg::TR_ENTRY_W-1:0]      tr_wdata,
	input  logic [tzl_pkg::TR_ENTRY_W-1:0]      tr_rdata,
	output logic                                ty_we,
	output logic [TY_AW-1:0]                    ty_addr,
	output logic [tzl_pkg::TY_ENTRY_W-1:0]      ty_wdata,
	input  logic [tzl_pkg::TY_ENTRY_W-1:0]      ty_rdata,
	input  logic                                res_free,
	output tzl_pkg::result_t                    res
);

	tzl_pkg::state_t                        state_q, state_d;
	logic [TRC_W-1:0]                       idx_q, idx_d, idx_nx;
	logic [tzl_pkg::TTYPE_W-1:0]            sel_q, sel_d, sel_nx;
	tzl_pkg::status_t                       stat_q, stat_d;
	logic signed [tzl_pkg::QTIME_W-1:0]     query_q;
	logic [tzl_pkg::TY_ENTRY_W-1:0]         data_q;
	logic [tzl_pkg::TTIME_W-1:0]            rd_time;
	logic [tzl_pkg::TTYPE_W-1:0]            rd_type;
	logic                                   at_or_before;
	logic                                   finish;
	logic                                   take_query;

	assign rd_time      = tr_rdata[tzl_pkg::TTIME_W-1:0];
	assign rd_type      = tr_rdata[tzl_pkg::TR_ENTRY_W-1:tzl_pkg::TTIME_W];
	assign at_or_before = $signed({{(tzl_pkg::QTIME_W - tzl_pkg::TTIME_W){rd_time[tzl_pkg::TTIME_W-1]}},
		rd_time}) <= query_q;
	assign idx_nx       = idx_q + TRC_W'(1);
	assign tr_wdata     = {transition_type, transition_time};
	assign ty_wdata     = {type_abbrev, type_dst, type_offset};
	assign in_ready     = (state_q == tzl_pkg::S_IDLE);
	assign take_query   = in_valid && in_ready && (cmd == tzl_pkg::CMD_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tzl_pkg::S_IDLE;
			idx_q   <= '0;
			sel_q   <= '0;
			stat_q  <= tzl_pkg::STATUS_OK;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sel_q   <= sel_d;
			stat_q  <= stat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_query) begin
			query_q <= query_time;
		end
		if (state_q == tzl_pkg::S_TYPE_RD) begin
			data_q <= ty_rdata;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		sel_d   = sel_q;
		stat_d  = stat_q;
		sel_nx  = sel_q;
		finish  = 1'b0;
		tr_we   = 1'b0;
		ty_we   = 1'b0;
		tr_addr = TR_AW'(entry_index);
		ty_addr = TY_AW'(entry_index);
		res     = '0;

		case (state_q)
			tzl_pkg::S_IDLE: begin
				if (in_valid) begin
					case (tzl_pkg::cmd_t'(cmd))
						tzl_pkg::CMD_WR_TRANS: begin
							tr_we = (32'(entry_index) < MAX_TRANSITIONS);
						end
						tzl_pkg::CMD_WR_TYPE: begin
							ty_we = (32'(entry_index) < MAX_TYPES);
						end
						tzl_pkg::CMD_QUERY: begin
							sel_d = '0;
							idx_d = '0;
							if (nty == '0) begin
								stat_d  = tzl_pkg::STATUS_NO_DATA;
								state_d = tzl_pkg::S_DONE;
							end else if (ntr == '0) begin
								ty_addr = '0;
								stat_d  = tzl_pkg::STATUS_OK;
								state_d = tzl_pkg::S_TYPE_RD;
							end else begin
								tr_addr = '0;
								state_d = tzl_pkg::S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			tzl_pkg::S_SCAN: begin
				if (at_or_before) begin
					sel_nx = rd_type;
					sel_d  = rd_type;
					if (idx_nx < ntr) begin
						idx_d   = idx_nx;
						tr_addr = TR_AW'(idx_nx);
					end else begin
						finish = 1'b1;
					end
				end else begin
					finish = 1'b1;
				end
				if (finish) begin
					if (32'(sel_nx) >= 32'(nty)) begin
						stat_d  = tzl_pkg::STATUS_BAD_TYPE;
						state_d = tzl_pkg::S_DONE;
					end else begin
						ty_addr = TY_AW'(sel_nx);
						stat_d  = tzl_pkg::STATUS_OK;
						state_d = tzl_pkg::S_TYPE_RD;
					end
				end
			end
			tzl_pkg::S_TYPE_RD: begin
				state_d = tzl_pkg::S_DONE;
			end
			tzl_pkg::S_DONE: begin
				res.valid  = 1'b1;
				res.status = stat_q;
				if (stat_q == tzl_pkg::STATUS_OK) begin
					res.offset = data_q[tzl_pkg::OFFSET_W-1:0];
					res.dst    = data_q[tzl_pkg::OFFSET_W];
					res.abbrev = data_q[tzl_pkg::TY_ENTRY_W-1:tzl_pkg::OFFSET_W+1];
				end
				if (res_free) begin
					state_d = tzl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tzl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[sv/tz_transition_lookup.sv]
// Top level of the time-zone transition lookup: configuration registers, the two
// table RAMs, the sequencer and the output register. Depends on tzl_pkg, tzl_ram, tzl_scan.
//
// A query walks the transition table in order, one entry per cycle through the single
// read port of the transition RAM, stopping at the first transition later than the
// query time; it then reads the type RAM once, unless the selected type index is out
// of range. The walk covers at most the saturated transition_count entries; with no
// transitions it is skipped, and with no types neither table is read. Results wait in
// an output register, so the next transfer is taken while a result is pending; a query
// that finishes while that register is still full waits until it drains.
module tz_transition_lookup #(
	parameter int MAX_TRANSITIONS = tzl_pkg::DEF_MAX_TRANSITIONS,
	parameter int MAX_TYPES       = tzl_pkg::DEF_MAX_TYPES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tzl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tzl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// entry_index, transition_time, transition_type, type_offset, type_dst,
	// type_abbrev, query_time, then zero padding
	input  logic [tzl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// cmd
	input  logic [tzl_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// utc_offset, is_daylight, abbrev_index, then zero padding
	output logic [tzl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// status
	output logic [tzl_pkg::STATUS_W-1:0]      m_axis_tuser
);

	localparam int TR_AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
	localparam int TY_AW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
	localparam int TRC_W = $clog2(MAX_TRANSITIONS + 1);
	localparam int TYC_W = $clog2(MAX_TYPES + 1);
	localparam int RES_W = tzl_pkg::OFFSET_W + 1 + tzl_pkg::ABBREV_W;

	logic [tzl_pkg::TRCFG_W-1:0]       tr_count_q;
	logic [tzl_pkg::TYCFG_W-1:0]       ty_count_q;
	logic [TRC_W-1:0]                  ntr;
	logic [TYC_W-1:0]                  nty;
	logic                              tr_we, ty_we;
	logic [TR_AW-1:0]                  tr_addr;
	logic [TY_AW-1:0]                  ty_addr;
	logic [tzl_pkg::TR_ENTRY_W-1:0]    tr_wdata, tr_rdata;
	logic [tzl_pkg::TY_ENTRY_W-1:0]    ty_wdata, ty_rdata;
	logic                              res_free;
	tzl_pkg::result_t                  res;
	logic                              m_valid_q;
	logic [RES_W-1:0]                  m_data_q;
	logic [tzl_pkg::STATUS_W-1:0]      m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_count_q <= '0;
			ty_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tzl_pkg::REG_TRANSITION_COUNT: tr_count_q <= cfg_data[tzl_pkg::TRCFG_W-1:0];
				tzl_pkg::REG_TYPE_COUNT:       ty_count_q <= cfg_data[tzl_pkg::TYCFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign ntr = (32'(tr_count_q) > MAX_TRANSITIONS) ? TRC_W'(MAX_TRANSITIONS) : TRC_W'(tr_count_q);
	assign nty = (32'(ty_count_q) > MAX_TYPES) ? TYC_W'(MAX_TYPES) : TYC_W'(ty_count_q);

	tzl_ram #(
		.DEPTH (MAX_TRANSITIONS),
		.WIDTH (tzl_pkg::TR_ENTRY_W)
	) u_tr_ram (
		.clk   (clk),
		.we    (tr_we),
		.addr  (tr_addr),
		.wdata (tr_wdata),
		.rdata (tr_rdata)
	);

	tzl_ram #(
		.DEPTH (MAX_TYPES),
		.WIDTH (tzl_pkg::TY_ENTRY_W)
	) u_ty_ram (
		.clk   (clk),
		.we    (ty_we),
		.addr  (ty_addr),
		.wdata (ty_wdata),
		.rdata (ty_rdata)
	);

	tzl_scan #(
		.MAX_TRANSITIONS (MAX_TRANSITIONS),
		.MAX_TYPES       (MAX_TYPES)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.cmd             (s_axis_tuser),
		.entry_index     (s_axis_tdata[9:0]),
		.transition_time (s_axis_tdata[41:10]),
		.transition_type (s_axis_tdata[49:42]),
		.type_offset     (s_axis_tdata[81:50]),
		.type_dst        (s_axis_tdata[82]),
		.type_abbrev     (s_axis_tdata[90:83]),
		.query_time      (s_axis_tdata[154:91]),
		.ntr             (ntr),
		.nty             (nty),
		.tr_we           (tr_we),
		.tr_addr         (tr_addr),
		.tr_wdata        (tr_wdata),
		.tr_rdata        (tr_rdata),
		.ty_we           (ty_we),
		.ty_addr         (ty_addr),
		.ty_wdata        (ty_wdata),
		.ty_rdata        (ty_rdata),
		.res_free        (res_free),
		.res             (res)
	);

	assign res_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid && res_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_free) begin
			m_data_q <= {res.abbrev, res.dst, res.offset};
			m_user_q <= res.status;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(tzl_pkg::OUT_DATA_W - RES_W)'(0), m_data_q};
	assign m_axis_tuser  = m_user_q;

endmodule
